/* rtl/set_assoc_cache_tag_lookup_macros.svh */
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup: assertion macros
// Shared property macros for the controller and the datapath. Defining
// NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define SACL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("sacl: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define SACL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sacl: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sacl: assertion failed");

`else

`define SACL_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define SACL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SACL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup: shared package
// Parameter defaults, register codes, reset values, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacl_pkg;

	// Parameter defaults.
	localparam int DEF_SETS      = 64;
	localparam int DEF_WAYS      = 8;
	localparam int DEF_ADDR_BITS = 32;

	// Configuration register indexes.
	localparam logic [1:0] CFG_POLICY      = 2'd0;
	localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] CFG_INDEX_BITS  = 2'd2;
	localparam logic [1:0] CFG_WAYS_IN_USE = 2'd3;

	// Replacement policy codes; any other code always replaces way 0.
	localparam logic [1:0] POLICY_LRU  = 2'd0;
	localparam logic [1:0] POLICY_FIFO = 2'd1;

	// Register reset values.
	localparam logic [1:0] RST_POLICY      = POLICY_LRU;
	localparam logic [3:0] RST_OFFSET_BITS = 4'd6;
	localparam logic [2:0] RST_INDEX_BITS  = 3'd6;
	localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INDEX,
		S_READ,
		S_MATCH,
		S_VICTIM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear_write;
		logic cap_addr;
		logic calc_index;
		logic mem_read;
		logic match;
		logic victim_step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic need_victim;
		logic victim_last;
	} status_t;

endpackage

/* rtl/set_assoc_cache_tag_lookup.sv */
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup with LRU / FIFO replacement
// A miss into a full set under LRU or FIFO adds a victim scan over the ways in use.
// A new input beat is taken only once the previous one has been committed; the pace is
// set by the row memory read-modify-write and the serial scan.
// Reset: asynchronous; a clearing pass over all SETS rows marks every line invalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Block overview
//
// Each input beat carries one byte address. The controller walks the beat
// through a fixed sequence of steps while the datapath does the work:
//
//   capture  - the address is narrowed to ADDR_BITS and registered.
//   index    - the address is split into offset, set index and tag using the
//              configured bit counts; the set index is reduced modulo SETS.
//   read     - the whole set row (valid bits, tags, last-use and fill times of
//              every way) is read from the row memory into registers.
//   match    - all ways in use are compared with the tag in parallel. A hit
//              picks the lowest matching way; a miss picks the lowest invalid
//              way, or way 0 when the set is full.
//   victim   - only on a miss into a full set under LRU or FIFO: the ways are
//              scanned one per cycle for the strictly smallest last-use or fill
//              time, so ties go to the lowest way.
//   commit   - the updated row is written back, the access, hit and miss
//              counters advance and the result is loaded into the output
//              register.
//
// The output register lets the result beat wait while the controller returns
// to idle and takes the next address; a commit only waits if the previous
// result has not been taken yet.
//
// After reset the controller sweeps the row memory one set per cycle and
// clears the valid bits before it takes the first beat. Configuration writes
// are taken at any time and are meant to happen only while no beat is in
// flight.

module set_assoc_cache_tag_lookup #(
	parameter int SETS      = sacl_pkg::DEF_SETS,
	parameter int WAYS      = sacl_pkg::DEF_WAYS,
	parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,

	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data,

	// Address channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] address,

	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [2:0]  way_used,
	output logic        evicted,
	output logic [31:0] access_count,
	output logic [31:0] hit_count,
	output logic [31:0] miss_count
);

	// Command and status bundles between the controller and the datapath.
	sacl_pkg::cmd_t    cmd;
	sacl_pkg::status_t status;

	// Step sequencing, clearing pass and output handshake.
	sacl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Registers, row memory, compare and counters.
	sacl_datapath #(
		.SETS      (SETS),
		.WAYS      (WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.address      (address),
		.hit          (hit),
		.way_used     (way_used),
		.evicted      (evicted),
		.access_count (access_count),
		.hit_count    (hit_count),
		.miss_count   (miss_count),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

/* rtl/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup: controller
// Sequences the clearing pass, the lookup steps of one beat and the output
// register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_macros.svh"

module sacl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  sacl_pkg::status_t status,
	output sacl_pkg::cmd_t   cmd
);

	sacl_pkg::state_t state_q;
	sacl_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacl_pkg::S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sacl_pkg::S_CLEAR: begin
				if (status.clear_last) state_nxt = sacl_pkg::S_IDLE;
			end
			sacl_pkg::S_IDLE: begin
				if (in_valid) state_nxt = sacl_pkg::S_INDEX;
			end
			sacl_pkg::S_INDEX: begin
				state_nxt = sacl_pkg::S_READ;
			end
			sacl_pkg::S_READ: begin
				state_nxt = sacl_pkg::S_MATCH;
			end
			sacl_pkg::S_MATCH: begin
				state_nxt = status.need_victim ? sacl_pkg::S_VICTIM : sacl_pkg::S_DONE;
			end
			sacl_pkg::S_VICTIM: begin
				if (status.victim_last) state_nxt = sacl_pkg::S_DONE;
			end
			sacl_pkg::S_DONE: begin
				if (out_free) state_nxt = sacl_pkg::S_IDLE;
			end
			default: begin
				state_nxt = sacl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd             = '0;
		in_stall        = (state_q != sacl_pkg::S_IDLE);
		cmd.clear_write = (state_q == sacl_pkg::S_CLEAR);
		cmd.cap_addr    = (state_q == sacl_pkg::S_IDLE) && in_valid;
		cmd.calc_index  = (state_q == sacl_pkg::S_INDEX);
		cmd.mem_read    = (state_q == sacl_pkg::S_READ);
		cmd.match       = (state_q == sacl_pkg::S_MATCH);
		cmd.victim_step = (state_q == sacl_pkg::S_VICTIM);
		cmd.commit      = (state_q == sacl_pkg::S_DONE) && out_free;
	end

	`SACL_ASSERT_IMPL(a_commit_room, clk, arst_n, cmd.commit, !(out_valid_q && out_stall))
	`SACL_ASSERT_NEXT(a_commit_shows, clk, arst_n, cmd.commit, out_valid_q)
	`SACL_ASSERT_IMPL(a_no_take_in_clear, clk, arst_n, state_q == sacl_pkg::S_CLEAR, !cmd.cap_addr)

endmodule

/* rtl/sacl_datapath.sv */
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup: datapath
// Configuration registers, address split, set row memory, way compare,
// victim scan, statistics counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_macros.svh"

module sacl_datapath #(
	parameter int SETS      = sacl_pkg::DEF_SETS,
	parameter int WAYS      = sacl_pkg::DEF_WAYS,
	parameter int ADDR_BITS = sacl_pkg::DEF_ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	input  logic [31:0]       address,
	output logic              hit,
	output logic [2:0]        way_used,
	output logic              evicted,
	output logic [31:0]       access_count,
	output logic [31:0]       hit_count,
	output logic [31:0]       miss_count,
	input  sacl_pkg::cmd_t    cmd,
	output sacl_pkg::status_t status
);

	localparam int SIDX = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NWB  = $clog2(WAYS + 1);
	localparam logic [31:0] ADDR_MASK =
		(ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [12:0] SETS_W   = 13'(SETS);
	localparam logic [4:0]  WAYS_W   = 5'(WAYS);
	localparam logic [NWB-1:0] WAYS_N = NWB'(WAYS);

	// Configuration registers.
	logic [1:0] policy_q;
	logic [3:0] offset_bits_q;
	logic [2:0] index_bits_q;
	logic [3:0] ways_in_use_q;

	// Per-beat working registers.
	logic [31:0]      addr_q;
	logic [SIDX-1:0]  set_q;
	logic [31:0]      tag_q;
	logic [SIDX-1:0]  clr_q;

	// Set row memory: one row holds every way of one set.
	logic [WAYS-1:0]        mem_valid [SETS];
	logic [WAYS-1:0][31:0]  mem_tag   [SETS];
	logic [WAYS-1:0][31:0]  mem_last  [SETS];
	logic [WAYS-1:0][31:0]  mem_fill  [SETS];

	logic [WAYS-1:0]        rd_valid_q;
	logic [WAYS-1:0][31:0]  rd_tag_q;
	logic [WAYS-1:0][31:0]  rd_last_q;
	logic [WAYS-1:0][31:0]  rd_fill_q;

	// Match and victim results.
	logic            m_hit_q;
	logic            m_evict_q;
	logic [WIDX-1:0] m_way_q;
	logic [WIDX-1:0] vw_q;
	logic [31:0]     least_q;

	// Counters and result register.
	logic [31:0] access_q;
	logic [31:0] hits_q;
	logic [31:0] misses_q;
	logic        res_hit_q;
	logic [2:0]  res_way_q;
	logic        res_evict_q;

	// Combinational helpers.
	logic [NWB-1:0]  nways;
	logic [31:0]     shifted;
	logic [6:0]      set_raw;
	logic [12:0]     set_rem;
	logic [4:0]      tag_shamt;
	logic [31:0]     tag_calc;
	logic [WAYS-1:0] hit_vec;
	logic [WAYS-1:0] free_vec;
	logic            any_hit;
	logic            any_free;
	logic [WIDX-1:0] hit_way;
	logic [WIDX-1:0] free_way;
	logic [31:0]     vic_time;
	logic [31:0]     clock_nxt;
	logic [WAYS-1:0]       new_valid;
	logic [WAYS-1:0][31:0] new_tag;
	logic [WAYS-1:0][31:0] new_last;
	logic [WAYS-1:0][31:0] new_fill;

	// Ways in use, held to the range one to WAYS.
	always_comb begin
		if (ways_in_use_q == 4'd0) begin
			nways = NWB'(1);
		end else if ({1'b0, ways_in_use_q} > WAYS_W) begin
			nways = WAYS_N;
		end else begin
			nways = NWB'(ways_in_use_q);
		end
	end

	// Address split. The set index is reduced modulo SETS by a short
	// restoring remainder over its seven bits.
	always_comb begin
		shifted   = addr_q >> offset_bits_q;
		set_raw   = shifted[6:0] & ~(7'h7f << index_bits_q);
		set_rem   = '0;
		for (int i = 6; i >= 0; i--) begin
			set_rem = {set_rem[11:0], set_raw[i]};
			if (set_rem >= SETS_W) set_rem = set_rem - SETS_W;
		end
		tag_shamt = 5'(offset_bits_q) + 5'(index_bits_q);
		tag_calc  = addr_q >> tag_shamt;
	end

	// Way compare over the registered row, lowest way first.
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w]  = (NWB'(w) < nways) && rd_valid_q[w] && (rd_tag_q[w] == tag_q);
			free_vec[w] = (NWB'(w) < nways) && !rd_valid_q[w];
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) hit_way = WIDX'(w);
			if (free_vec[w]) free_way = WIDX'(w);
		end
		any_hit  = |hit_vec;
		any_free = |free_vec;
	end

	assign vic_time = (policy_q == sacl_pkg::POLICY_LRU) ? rd_last_q[vw_q] : rd_fill_q[vw_q];

	assign status.clear_last  = (clr_q == SIDX'(SETS - 1));
	assign status.need_victim = !any_hit && !any_free &&
		(policy_q == sacl_pkg::POLICY_LRU || policy_q == sacl_pkg::POLICY_FIFO);
	assign status.victim_last = ((NWB'(vw_q) + NWB'(1)) == nways);

	// Row update for the commit.
	assign clock_nxt = access_q + 32'd1;

	always_comb begin
		new_valid = rd_valid_q;
		new_tag   = rd_tag_q;
		new_last  = rd_last_q;
		new_fill  = rd_fill_q;
		if (m_hit_q) begin
			if (policy_q == sacl_pkg::POLICY_LRU) new_last[m_way_q] = clock_nxt;
		end else begin
			new_valid[m_way_q] = 1'b1;
			new_tag[m_way_q]   = tag_q;
			new_last[m_way_q]  = clock_nxt;
			new_fill[m_way_q]  = clock_nxt;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= sacl_pkg::RST_POLICY;
			offset_bits_q <= sacl_pkg::RST_OFFSET_BITS;
			index_bits_q  <= sacl_pkg::RST_INDEX_BITS;
			ways_in_use_q <= sacl_pkg::RST_WAYS_IN_USE;
			clr_q         <= '0;
			vw_q          <= '0;
			access_q      <= '0;
			hits_q        <= '0;
			misses_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sacl_pkg::CFG_POLICY:      policy_q      <= cfg_data[1:0];
					sacl_pkg::CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
					sacl_pkg::CFG_INDEX_BITS:  index_bits_q  <= cfg_data[2:0];
					sacl_pkg::CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
					default:                   policy_q      <= policy_q;
				endcase
			end
			if (cmd.clear_write && !status.clear_last) clr_q <= clr_q + SIDX'(1);
			if (cmd.match) begin
				vw_q <= '0;
			end else if (cmd.victim_step) begin
				vw_q <= vw_q + WIDX'(1);
			end
			if (cmd.commit) begin
				access_q <= clock_nxt;
				if (m_hit_q) begin
					hits_q <= hits_q + 32'd1;
				end else begin
					misses_q <= misses_q + 32'd1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.cap_addr) addr_q <= address & ADDR_MASK;
		if (cmd.calc_index) begin
			set_q <= set_rem[SIDX-1:0];
			tag_q <= tag_calc;
		end
		if (cmd.match) begin
			m_hit_q   <= any_hit;
			m_evict_q <= !any_hit && !any_free;
			m_way_q   <= any_hit ? hit_way : (any_free ? free_way : '0);
			least_q   <= 32'hFFFF_FFFF;
		end else if (cmd.victim_step) begin
			if (vic_time < least_q) begin
				least_q <= vic_time;
				m_way_q <= vw_q;
			end
		end
		if (cmd.commit) begin
			res_hit_q   <= m_hit_q;
			res_way_q   <= 3'(m_way_q);
			res_evict_q <= m_evict_q;
		end
	end

	// Row memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear_write) begin
			mem_valid[clr_q] <= '0;
		end else if (cmd.commit) begin
			mem_valid[set_q] <= new_valid;
			mem_tag[set_q]   <= new_tag;
			mem_last[set_q]  <= new_last;
			mem_fill[set_q]  <= new_fill;
		end
		if (cmd.mem_read) begin
			rd_valid_q <= mem_valid[set_q];
			rd_tag_q   <= mem_tag[set_q];
			rd_last_q  <= mem_last[set_q];
			rd_fill_q  <= mem_fill[set_q];
		end
	end

	assign hit          = res_hit_q;
	assign way_used     = res_way_q;
	assign evicted      = res_evict_q;
	assign access_count = access_q;
	assign hit_count    = hits_q;
	assign miss_count   = misses_q;

	`SACL_ASSERT_IMPL(a_victim_on_full_miss, clk, arst_n, cmd.victim_step, !m_hit_q && m_evict_q)
	`SACL_ASSERT_NEXT(a_commit_counts, clk, arst_n, cmd.commit, hits_q + misses_q == access_q)

endmodule

/* tb/set_assoc_cache_tag_lookup_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Set-associative cache tag lookup: self-checking testbench
// Sends byte addresses into the lookup and compares every result beat with a
// predictor of the cache directory. The predictor keeps its own valid, tag,
// last-use and fill-time arrays. The run covers LRU, FIFO and way-0
// replacement, several address splits and way counts, out-of-range settings,
// and random stall and idle gaps on both channels.
// ----------------------------------------------------------------------------

localparam int LINE_COUNT = sacl_pkg::DEF_SETS * sacl_pkg::DEF_WAYS;

// One lookup result as seen on the result channel.
typedef struct packed {
	logic        hit;
	logic [2:0]  way;
	logic        evicted;
	logic [31:0] accesses;
	logic [31:0] hits;
	logic [31:0] misses;
} lookup_result_t;

// Cache directory predictor and the queue of lookups still owed by the block.
class cache_scoreboard;
	bit          line_valid[LINE_COUNT];
	logic [31:0] line_tag[LINE_COUNT];
	logic [31:0] line_last_use[LINE_COUNT];
	logic [31:0] line_fill_time[LINE_COUNT];
	logic [31:0] access_clock;
	logic [31:0] hits_total;
	logic [31:0] misses_total;

	logic [1:0]  policy;
	logic [3:0]  offset_bits;
	logic [2:0]  index_bits;
	logic [3:0]  ways_in_use;

	lookup_result_t expected_lookups[$];
	int errors;

	function new();
		for (int i = 0; i < LINE_COUNT; i++)
			line_valid[i] = 1'b0;
		access_clock = '0;
		hits_total   = '0;
		misses_total = '0;
		policy       = sacl_pkg::RST_POLICY;
		offset_bits  = sacl_pkg::RST_OFFSET_BITS;
		index_bits   = sacl_pkg::RST_INDEX_BITS;
		ways_in_use  = sacl_pkg::RST_WAYS_IN_USE;
		errors       = 0;
	endfunction

	function void set_register(logic [1:0] idx, logic [3:0] value);
		case (idx)
			sacl_pkg::CFG_POLICY:      policy      = value[1:0];
			sacl_pkg::CFG_OFFSET_BITS: offset_bits = value;
			sacl_pkg::CFG_INDEX_BITS:  index_bits  = value[2:0];
			sacl_pkg::CFG_WAYS_IN_USE: ways_in_use = value;
			default: ;
		endcase
	endfunction

	// Works out the lookup for one accepted address and queues the result.
	function void note_address(logic [31:0] addr);
		logic [63:0]    wide;
		logic [63:0]    set_sel;
		logic [31:0]    tag;
		logic [31:0]    least;
		logic [31:0]    stamp;
		int             base;
		int             nways;
		int             way;
		bit             found;
		bit             placed;
		lookup_result_t res;

		nways = int'(ways_in_use);
		if (nways < 1)
			nways = 1;
		if (nways > sacl_pkg::DEF_WAYS)
			nways = sacl_pkg::DEF_WAYS;

		access_clock = access_clock + 1;
		wide    = {32'd0, addr};
		set_sel = (wide >> offset_bits) & ((64'd1 << index_bits) - 64'd1);
		set_sel = set_sel % sacl_pkg::DEF_SETS;
		tag     = 32'(wide >> (int'(offset_bits) + int'(index_bits)));
		base    = int'(set_sel) * sacl_pkg::DEF_WAYS;

		found = 1'b0;
		way   = 0;
		for (int w = 0; w < nways; w++) begin
			if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
				found = 1'b1;
				way   = w;
			end
		end

		res = '0;
		if (found) begin
			hits_total = hits_total + 1;
			if (policy == sacl_pkg::POLICY_LRU)
				line_last_use[base + way] = access_clock;
		end else begin
			misses_total = misses_total + 1;
			placed = 1'b0;
			for (int w = 0; w < nways; w++) begin
				if (!placed && !line_valid[base + w]) begin
					placed = 1'b1;
					way    = w;
				end
			end
			if (!placed) begin
				// Full set: oldest time wins, strictly smaller only, so the
				// lowest way keeps a tie. Other policy codes take way 0.
				res.evicted = 1'b1;
				way = 0;
				if (policy == sacl_pkg::POLICY_LRU || policy == sacl_pkg::POLICY_FIFO) begin
					least = '1;
					for (int w = 0; w < nways; w++) begin
						stamp = (policy == sacl_pkg::POLICY_LRU) ? line_last_use[base + w]
							: line_fill_time[base + w];
						if (stamp < least) begin
							least = stamp;
							way   = w;
						end
					end
				end
			end
			line_valid[base + way]     = 1'b1;
			line_tag[base + way]       = tag;
			line_last_use[base + way]  = access_clock;
			line_fill_time[base + way] = access_clock;
		end

		res.hit      = found;
		res.way      = 3'(way);
		res.accesses = access_clock;
		res.hits     = hits_total;
		res.misses   = misses_total;
		expected_lookups.push_back(res);
	endfunction

	task report_mismatch(string msg);
		errors++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task check_field(string name, logic [31:0] got, logic [31:0] want, logic [31:0] nth);
		if (got !== want)
			report_mismatch($sformatf("access %0d %s: got %0h, expected %0h",
				nth, name, got, want));
	endtask

	task check_result(lookup_result_t got);
		lookup_result_t want;
		if (expected_lookups.size() == 0) begin
			report_mismatch($sformatf("result beat with no lookup pending (count %0d)",
				got.accesses));
		end else begin
			want = expected_lookups.pop_front();
			check_field("hit", 32'(got.hit), 32'(want.hit), want.accesses);
			check_field("way_used", 32'(got.way), 32'(want.way), want.accesses);
			check_field("evicted", 32'(got.evicted), 32'(want.evicted), want.accesses);
			check_field("access_count", got.accesses, want.accesses, want.accesses);
			check_field("hit_count", got.hits, want.hits, want.accesses);
			check_field("miss_count", got.misses, want.misses, want.accesses);
		end
	endtask
endclass

module set_assoc_cache_tag_lookup_tb;

	// Policy codes the package leaves unnamed: both always replace way 0.
	localparam logic [1:0] POLICY_WAY0     = 2'd2;
	localparam logic [1:0] POLICY_WAY0_ALT = 2'd3;

	// Cycles without any accepted beat before the run is declared hung. The
	// limit covers the slowest beat with a victim scan, plus a long stall and a long
	// gap, plus the clearing sweep after reset.
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PHASES = 10;
	localparam int BEATS_PER_PHASE = 70;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [3:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        hit;
	logic [2:0]  way_used;
	logic        evicted;
	logic [31:0] access_count;
	logic [31:0] hit_count;
	logic [31:0] miss_count;

	cache_scoreboard sb = new();

	// Address pools for the random phases: a few tags over a few sets, so
	// that sets fill up, hit again and evict.
	logic [31:0] tag_pool[12];
	int          tag_count;
	logic [6:0]  set_pool[3];
	bit          tx_steady;
	bit          rx_steady = 1'b0;
	int          rx_hold = 0;
	int          rx_gap;
	int          quiet_cycles = 0;
	lookup_result_t seen;

	set_assoc_cache_tag_lookup uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.address      (address),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.way_used     (way_used),
		.evicted      (evicted),
		.access_count (access_count),
		.hit_count    (hit_count),
		.miss_count   (miss_count)
	);

	always #1 clk = ~clk;

	// Gap length for either side: usually none, sometimes a few cycles, now
	// and then a long one. A steady stretch never idles.
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Result side: stall at random, independent of out_valid, so that
	// stalls also land while the block is still working on a beat.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			rx_steady <= ~rx_steady;
		if (rx_hold != 0) begin
			out_stall <= 1'b1;
			rx_hold <= rx_hold - 1;
		end else begin
			rx_gap = pick_gap(rx_steady);
			out_stall <= (rx_gap != 0);
			if (rx_gap != 0)
				rx_hold <= rx_gap - 1;
		end
	end

	// Every accepted address beat goes into the predictor at the edge that
	// takes it; every accepted result beat is checked at its edge.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_address(address);
		if (arst_n && out_valid && !out_stall) begin
			seen = {hit, way_used, evicted, access_count, hit_count, miss_count};
			sb.check_result(seen);
		end
	end

	// Hang detection: count edges at which neither channel moves a beat.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offers one address beat, after an optional idle gap, and returns at
	// the falling edge after the beat was taken. Valid stays high, so a
	// following call without a gap sends back to back.
	task automatic send_address(logic [31:0] addr);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		address  <= addr;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted lookup has come back.
	// Every address produces a result, so an empty queue means idle.
	task automatic drain_lookups();
		in_valid <= 1'b0;
		while (sb.expected_lookups.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [3:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.set_register(idx, value);
		@(negedge clk);
	endtask

	// Writes all four registers back to back, then draws new address pools
	// that fit the new split.
	task automatic apply_setting(logic [1:0] pol, logic [3:0] offs, logic [2:0] idx,
		logic [3:0] ways);
		int nways;
		write_register(sacl_pkg::CFG_POLICY, {2'b00, pol});
		write_register(sacl_pkg::CFG_OFFSET_BITS, offs);
		write_register(sacl_pkg::CFG_INDEX_BITS, {1'b0, idx});
		write_register(sacl_pkg::CFG_WAYS_IN_USE, ways);
		cfg_we <= 1'b0;
		nways = (ways == 0) ? 1 : ((int'(ways) > sacl_pkg::DEF_WAYS) ? sacl_pkg::DEF_WAYS
			: int'(ways));
		tag_count = $urandom_range(2, (nways + 3 > 12) ? 12 : nways + 3);
		foreach (tag_pool[i])
			tag_pool[i] = $urandom;
		foreach (set_pool[i])
			set_pool[i] = 7'($urandom);
		tx_steady = ($urandom_range(0, 3) == 0);
	endtask

	// Mostly addresses built from the pools with a random block offset; the
	// rest is fully random noise that reaches every address bit.
	function automatic logic [31:0] make_address();
		logic [31:0] addr;
		logic [31:0] offs;
		int shift;
		if ($urandom_range(0, 99) < 15)
			return $urandom;
		shift = int'(sb.offset_bits) + int'(sb.index_bits);
		offs  = $urandom;
		addr  = tag_pool[$urandom_range(0, tag_count - 1)] << shift;
		addr |= ((32'(set_pool[$urandom_range(0, 2)]) & ((32'd1 << sb.index_bits) - 1))
			<< sb.offset_bits);
		addr |= offs & ((32'd1 << sb.offset_bits) - 1);
		return addr;
	endfunction

	initial begin
		tx_steady = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset split (64-byte lines, 64 sets, 8 ways): lowest and highest
		// address, then a hit on the first line from another byte of it.
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_003F);

		// Fully associative, two ways, LRU: the hit refreshes a line so the
		// other one is evicted next, and the refill evicts in turn.
		drain_lookups();
		apply_setting(sacl_pkg::POLICY_LRU, 4'd0, 3'd0, 4'd2);
		send_address(32'h0000_0010);
		send_address(32'h0000_0020);
		send_address(32'h0000_0010);
		send_address(32'h0000_0030);
		send_address(32'h0000_0020);

		// Two ways under FIFO: each miss into the full set evicts the line filled first.
		drain_lookups();
		apply_setting(sacl_pkg::POLICY_FIFO, 4'd0, 3'd0, 4'd2);
		send_address(32'h0000_0040);
		send_address(32'h0000_0010);
		send_address(32'h0000_0050);
		send_address(32'h0000_0040);

		// Unknown policy with ways of zero (used as one), the widest offset
		// and an index wider than the sets, which wraps modulo the set count.
		drain_lookups();
		apply_setting(POLICY_WAY0_ALT, 4'd15, 3'd7, 4'd0);
		send_address(32'h0000_0000);
		send_address(32'h0080_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0000);

		// Other unknown policy code on three ways: full sets replace way 0.
		drain_lookups();
		apply_setting(POLICY_WAY0, 4'd12, 3'd6, 4'd3);
		send_address(32'h0000_1000);
		send_address(32'h0004_1000);
		send_address(32'h0008_1000);
		send_address(32'h000C_1000);

		// Random phases: fixed settings with the extremes first, then random
		// settings over the full register widths.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_lookups();
			case (phase)
				0: apply_setting(sacl_pkg::POLICY_LRU, 4'd6, 3'd6, 4'd8);
				1: apply_setting(sacl_pkg::POLICY_FIFO, 4'd4, 3'd2, 4'd4);
				2: apply_setting(POLICY_WAY0, 4'd0, 3'd0, 4'd8);
				3: apply_setting(POLICY_WAY0_ALT, 4'd12, 3'd6, 4'd2);
				4: apply_setting(sacl_pkg::POLICY_LRU, 4'd15, 3'd7, 4'd15);
				5: apply_setting(sacl_pkg::POLICY_FIFO, 4'd0, 3'd0, 4'd0);
				6: apply_setting(sacl_pkg::POLICY_LRU, 4'd2, 3'd3, 4'd9);
				default: apply_setting(2'($urandom), 4'($urandom), 3'($urandom),
					4'($urandom));
			endcase
			for (int n = 0; n < BEATS_PER_PHASE; n++)
				send_address(make_address());
		end

		// Let any stray result beat show up before the verdict.
		drain_lookups();
		repeat (20) @(negedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
